>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked by i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/bfw_pkg.sv
// ----------------------------------------------------------------------------
// Bicubic flow warp package
// Sizes, word types and codes shared by the warp unit modules.
// ----------------------------------------------------------------------------
package bfw_pkg;

    localparam int MAX_WIDTH    = 512;
    localparam int MAX_HEIGHT   = 512;
    localparam int MAX_CHANNELS = 4;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int FRAME_W      = ADDR_W + 1;
    localparam int DIM_W        = 10;
    localparam int CH_W         = 3;
    localparam int POS_W        = $clog2(MAX_WIDTH);
    localparam int LANE_W       = 2;
    localparam int STRIDE_W     = DIM_W + CH_W;
    localparam int ACC_W        = 64;

    // Configuration register indexes.
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    // Opcodes of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WARP = 1'b1;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] sample_value;
        logic signed [15:0] flow_dx;
        logic signed [15:0] flow_dy;
    } t_in;

    typedef struct packed {
        logic signed [23:0] warped_value;
        logic               value_valid;
        logic [1:0]         channel_index;
        logic               last_channel;
    } t_out;

    // Request to the cubic unit.
    typedef struct packed {
        logic       start;
        logic [4:0] t;
    } t_cub_req;

endpackage

>>> hw/rtl/bicubic_flow_warp_unit.sv
// A load word is written to the frame store when accepted; a warp word runs the
// sequencer once per channel, skipping reads when a neighbor lies outside the image.
// Each channel reads 16 neighbors from the single-port frame store, one per cycle in
// bursts of four, and runs five cubic evaluations on the shared cubic unit.
// One word at a time; loads run at one per cycle unless a configuration write stalls.
// Reset: synchronous, active low; restores 512 x 512 with one channel, store kept.
// ----------------------------------------------------------------------------
// Bicubic flow warp unit
// Frame store loader and sequencer that warps each destination pixel by its
// flow vector with separable Keys cubic interpolation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bicubic_flow_warp_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bfw_pkg::t_in        i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bfw_pkg::t_out       o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data
);
    import bfw_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POS    = 4'd1;
    localparam logic [3:0] S_MUL1   = 4'd2;
    localparam logic [3:0] S_MUL2   = 4'd3;
    localparam logic [3:0] S_CHAN   = 4'd4;
    localparam logic [3:0] S_RD     = 4'd5;
    localparam logic [3:0] S_WAIT   = 4'd6;
    localparam logic [3:0] S_VSTART = 4'd7;
    localparam logic [3:0] S_VRUN   = 4'd8;
    localparam logic [3:0] S_HSTART = 4'd9;
    localparam logic [3:0] S_HRUN   = 4'd10;
    localparam logic [3:0] S_ROUND  = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    logic [3:0]              r_state;
    logic [DIM_W-1:0]        r_w;
    logic [DIM_W-1:0]        r_h;
    logic [CH_W-1:0]         r_ch;
    logic [1:0]              r_settle;
    logic [2*DIM_W-1:0]      r_wh;
    logic [FRAME_W-1:0]      r_frame;
    logic [ADDR_W-1:0]       r_ptr;
    logic [POS_W-1:0]        r_dcol;
    logic [POS_W-1:0]        r_drow;
    logic [POS_W-1:0]        r_col_cur;
    logic [POS_W-1:0]        r_row_cur;
    logic signed [15:0]      r_dx;
    logic signed [15:0]      r_dy;
    logic [4:0]              r_tx;
    logic [4:0]              r_ty;
    logic [POS_W-1:0]        r_ix;
    logic [POS_W-1:0]        r_iy;
    logic                    r_valid;
    logic [ADDR_W-1:0]       r_lin;
    logic [ADDR_W-1:0]       r_base;
    logic [STRIDE_W-1:0]     r_stride;
    logic [LANE_W-1:0]       r_lane;
    logic [ADDR_W-1:0]       r_cbase;
    logic [ADDR_W-1:0]       r_addr;
    logic [1:0]              r_i;
    logic [1:0]              r_j;
    logic                    r_rd_pend;
    logic [1:0]              r_rd_idx;
    t_acc                    r_v [4];
    t_acc                    r_colv [4];
    t_acc                    r_q;
    logic signed [23:0]      r_res;
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    in_acc;
    logic                    out_free;
    logic                    is_last;
    logic [ADDR_W-1:0]       ptr_eff;
    logic [FRAME_W-1:0]      ptr_inc;
    logic                    pos_wrap;
    logic signed [17:0]      px;
    logic signed [17:0]      py;
    logic signed [12:0]      fx;
    logic signed [12:0]      fy;
    logic                    pos_ok;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_addr;
    logic [15:0]             mem_rdata;
    t_cub_req                cub_req;
    t_acc                    cub_v [4];
    logic                    cub_done;
    t_acc                    cub_res;
    t_acc                    rnd;
    t_acc                    rnd_sh;
    logic [POS_W:0]          col_inc;
    logic [POS_W:0]          row_inc;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        r = v;
        if (v < DIM_W'(4)) begin
            r = DIM_W'(4);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE) && (r_settle == 2'd0);
    assign out_free   = !r_out_valid || i_out_ready;
    assign is_last    = ({1'b0, r_lane} == r_ch - CH_W'(1));

    // Configuration registers, clamped on write, and the derived frame size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= DIM_W'(MAX_WIDTH);
            r_h      <= DIM_W'(MAX_HEIGHT);
            r_ch     <= CH_W'(1);
            r_settle <= 2'd3;
        end else begin
            if (i_cfg_we) begin
                r_settle <= 2'd3;
                case (i_cfg_index)
                    REG_WIDTH:    r_w <= clamp_dim(i_cfg_data, DIM_W'(MAX_WIDTH));
                    REG_HEIGHT:   r_h <= clamp_dim(i_cfg_data, DIM_W'(MAX_HEIGHT));
                    REG_CHANNELS: begin
                        if (i_cfg_data[CH_W-1:0] == CH_W'(0)) begin
                            r_ch <= CH_W'(1);
                        end else if (i_cfg_data[CH_W-1:0] > CH_W'(MAX_CHANNELS)) begin
                            r_ch <= CH_W'(MAX_CHANNELS);
                        end else begin
                            r_ch <= i_cfg_data[CH_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wh    <= r_w * r_h;
        r_frame <= FRAME_W'(r_wh * r_ch);
    end

    // Load pointer handling.
    always_comb begin
        ptr_eff = ({1'b0, r_ptr} >= r_frame) ? '0 : r_ptr;
        ptr_inc = {1'b0, ptr_eff} + FRAME_W'(1);
    end

    assign pos_wrap = ({1'b0, r_dcol} >= r_w) || ({1'b0, r_drow} >= r_h);

    // Source position: floor and fraction of the Q5 point.
    always_comb begin
        px     = $signed({4'b0, r_col_cur, 5'b0}) + 18'(r_dx);
        py     = $signed({4'b0, r_row_cur, 5'b0}) + 18'(r_dy);
        fx     = 13'(px >>> 5);
        fy     = 13'(py >>> 5);
        pos_ok = (fx >= 13'sd1) && (fy >= 13'sd1)
              && (fx <= $signed({3'b0, r_w}) - 13'sd3)
              && (fy <= $signed({3'b0, r_h}) - 13'sd3);
    end

    assign mem_we   = in_acc && (i_in_data.opcode == OP_LOAD);
    assign mem_addr = mem_we ? ptr_eff : r_addr;

    bfw_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_in_data.sample_value),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        cub_req.start = (r_state == S_VSTART) || (r_state == S_HSTART);
        cub_req.t     = (r_state == S_HSTART) ? r_tx : r_ty;
        for (int k = 0; k < 4; k++) begin
            cub_v[k] = (r_state == S_HSTART) ? r_colv[k] : r_v[k];
        end
    end

    bfw_cubic u_cubic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (cub_req),
        .i_v      (cub_v),
        .o_done   (cub_done),
        .o_result (cub_res)
    );

    // Q32 to Q4 with round half up, then saturation.
    always_comb begin
        rnd    = r_q + (t_acc'(1) <<< 27);
        rnd_sh = rnd >>> 28;
    end

    assign col_inc = {1'b0, r_col_cur} + (POS_W+1)'(1);
    assign row_inc = {1'b0, r_row_cur} + (POS_W+1)'(1);

    // Sample capture from the store.
    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_v[r_rd_idx] <= t_acc'($signed(mem_rdata));
        end
        r_rd_idx <= r_j;
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_dcol      <= '0;
            r_drow      <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A read issued in this cycle returns its data in the next one.
            r_rd_pend <= (r_state == S_RD);
            if (r_out_valid && i_out_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.opcode == OP_LOAD) begin
                            r_ptr <= (ptr_inc >= r_frame) ? '0 : ptr_inc[ADDR_W-1:0];
                        end else begin
                            r_col_cur <= pos_wrap ? '0 : r_dcol;
                            r_row_cur <= pos_wrap ? '0 : r_drow;
                            r_dx      <= i_in_data.flow_dx;
                            r_dy      <= i_in_data.flow_dy;
                            r_state   <= S_POS;
                        end
                    end
                end
                S_POS: begin
                    r_tx    <= px[4:0];
                    r_ty    <= py[4:0];
                    r_ix    <= POS_W'(fx - 13'sd1);
                    r_iy    <= POS_W'(fy - 13'sd1);
                    r_valid <= pos_ok;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_lin   <= ADDR_W'(r_iy * r_w) + ADDR_W'(r_ix);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_base   <= ADDR_W'(r_lin * r_ch);
                    r_stride <= r_w * r_ch;
                    r_lane   <= '0;
                    r_state  <= S_CHAN;
                end
                S_CHAN: begin
                    if (r_valid) begin
                        r_cbase <= r_base + ADDR_W'(r_lane);
                        r_addr  <= r_base + ADDR_W'(r_lane);
                        r_i     <= 2'd0;
                        r_j     <= 2'd0;
                        r_state <= S_RD;
                    end else begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_RD: begin
                    r_addr    <= r_addr + ADDR_W'(r_stride);
                    r_j       <= r_j + 2'd1;
                    if (r_j == 2'd3) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT:   r_state <= S_VSTART;
                S_VSTART: r_state <= S_VRUN;
                S_VRUN: begin
                    if (cub_done) begin
                        r_colv[r_i] <= cub_res;
                        if (r_i == 2'd3) begin
                            r_state <= S_HSTART;
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_cbase <= r_cbase + ADDR_W'(r_ch);
                            r_addr  <= r_cbase + ADDR_W'(r_ch);
                            r_j     <= 2'd0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_HSTART: r_state <= S_HRUN;
                S_HRUN: begin
                    if (cub_done) begin
                        r_q     <= cub_res;
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (rnd_sh > t_acc'(24'sh7FFFFF)) begin
                        r_res <= 24'sh7FFFFF;
                    end else if (rnd_sh < t_acc'(24'sh800000)) begin
                        r_res <= 24'sh800000;
                    end else begin
                        r_res <= rnd_sh[23:0];
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out.warped_value  <= r_res;
                        r_out.value_valid   <= r_valid;
                        r_out.channel_index <= r_lane;
                        r_out.last_channel  <= is_last;
                        if (is_last) begin
                            if ({1'b0, col_inc} >= r_w) begin
                                r_dcol <= '0;
                                r_drow <= ({1'b0, row_inc} >= r_h) ? '0 : row_inc[POS_W-1:0];
                            end else begin
                                r_dcol <= col_inc[POS_W-1:0];
                                r_drow <= r_row_cur;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_lane  <= r_lane + LANE_W'(1);
                            r_state <= S_CHAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks.
    `ASSERT_CLK(a_cub_done_state, cub_done |-> (r_state == S_VRUN || r_state == S_HRUN), "cubic result outside a run state")
    `ASSERT_CLK(a_last_lane, (o_out_valid && o_out_data.last_channel) |-> ({1'b0, o_out_data.channel_index} == r_ch - CH_W'(1)), "last word not on the final channel")
    `ASSERT_CLK(a_invalid_zero, (o_out_valid && !o_out_data.value_valid) |-> (o_out_data.warped_value == 24'sd0), "invalid word carries a value")
    `ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "output word present after reset")

endmodule

>>> hw/rtl/bfw_store.sv
// ----------------------------------------------------------------------------
// Frame store
// Single-port sample memory with a registered read.
// ----------------------------------------------------------------------------
module bfw_store (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [bfw_pkg::ADDR_W-1:0] i_addr,
    input  logic [15:0]               i_wdata,
    output logic [15:0]               o_rdata
);
    import bfw_pkg::*;

    logic [15:0] r_mem [STORE_DEPTH];

    // One access per cycle: a write or a read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

>>> hw/rtl/bfw_cubic.sv
// ----------------------------------------------------------------------------
// Keys cubic unit
// Evaluates 65536 times the Keys cubic (a = -0.5) at T/32 by Horner steps,
// one multiply by the fraction per cycle.
// ----------------------------------------------------------------------------
module bfw_cubic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfw_pkg::t_cub_req i_req,
    input  bfw_pkg::t_acc     i_v [4],
    output logic              o_done,
    output bfw_pkg::t_acc     o_result
);
    import bfw_pkg::*;

    t_acc             r_acc;
    t_acc             r_k [3];
    logic [4:0]       r_t;
    logic [1:0]       r_step;
    logic             r_busy;
    logic             r_done;
    t_acc             a_term;
    t_acc             b_term;
    t_acc             c_term;
    t_acc             d_term;
    logic signed [ACC_W+5:0] prod;

    // Polynomial coefficients from the four samples.
    always_comb begin
        a_term = 3 * (i_v[1] - i_v[2]) + i_v[3] - i_v[0];
        b_term = (2 * i_v[0] - 5 * i_v[1] + 4 * i_v[2] - i_v[3]) <<< 5;
        c_term = (i_v[2] - i_v[0]) <<< 10;
        d_term = i_v[1] <<< 16;
    end

    assign prod = r_acc * $signed({1'b0, r_t});

    // Horner sequence: three multiply-add steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc  <= a_term;
            r_k[0] <= b_term;
            r_k[1] <= c_term;
            r_k[2] <= d_term;
            r_t    <= i_req.t;
        end else if (r_busy) begin
            r_acc <= r_k[r_step] + prod[ACC_W-1:0];
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
